// ----- rtl/core/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, off during reset.
`define QAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/qau_pkg.sv -----
package qau_pkg;
  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 12;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_MUL = 2'd1,
    CMD_INV = 2'd2,
    CMD_MAG = 2'd3
  } qau_cmd_t;
endpackage

// ----- rtl/core/qau_req_if.sv -----
interface qau_req_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] a_w;
  logic signed [DATA_WIDTH-1:0] a_x;
  logic signed [DATA_WIDTH-1:0] a_y;
  logic signed [DATA_WIDTH-1:0] a_z;
  logic signed [DATA_WIDTH-1:0] b_w;
  logic signed [DATA_WIDTH-1:0] b_x;
  logic signed [DATA_WIDTH-1:0] b_y;
  logic signed [DATA_WIDTH-1:0] b_z;

  modport source (output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

// ----- rtl/core/qau_rsp_if.sv -----
interface qau_rsp_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_w;
  logic signed [DATA_WIDTH-1:0] r_x;
  logic signed [DATA_WIDTH-1:0] r_y;
  logic signed [DATA_WIDTH-1:0] r_z;
  logic [DATA_WIDTH-1:0]        magnitude;
  logic                         div_by_zero;

  modport source (output valid, r_w, r_x, r_y, r_z, magnitude, div_by_zero,
                  input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, magnitude, div_by_zero,
                output ready);
endinterface

// ----- rtl/core/qau_front.sv -----
// Stage 1 and 2: products, squares, sums; sum of squares out to the deep units.
module qau_front
  import qau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    in_cmd,
  input  logic signed [DATA_WIDTH-1:0]  in_a [4],
  input  logic signed [DATA_WIDTH-1:0]  in_b [4],
  output logic                          out_valid,
  output logic [1:0]                    out_cmd,
  output logic signed [DATA_WIDTH-1:0]  out_a [4],
  output logic signed [DATA_WIDTH-1:0]  out_quick [4],
  output logic [2*DATA_WIDTH+1:0]       out_sumsq
);
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned SW = PW + 3;
  localparam int unsigned RW = SW - FRAC_BITS;
  localparam logic signed [DATA_WIDTH-1:0] SMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // stage 1 registers
  logic                         v1_r;
  logic [1:0]                   cmd1_r;
  logic signed [DATA_WIDTH-1:0] a1_r [4];
  logic signed [DATA_WIDTH:0]   add1_r [4];
  logic signed [PW-1:0]         prod1_r [16];
  logic [PW-1:0]                sq1_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= in_cmd;
      for (int i = 0; i < 4; i++) begin
        a1_r[i]   <= in_a[i];
        add1_r[i] <= (DATA_WIDTH+1)'(in_a[i]) + (DATA_WIDTH+1)'(in_b[i]);
        sq1_r[i]  <= PW'(in_a[i] * in_a[i]);
        for (int j = 0; j < 4; j++) begin
          prod1_r[4*i+j] <= in_a[i] * in_b[j];
        end
      end
    end
  end

  function automatic logic signed [DATA_WIDTH-1:0] sat_add(
    input logic signed [DATA_WIDTH:0] v
  );
    logic signed [DATA_WIDTH:0] hi;
    logic signed [DATA_WIDTH:0] lo;
    hi = (DATA_WIDTH+1)'(SMax);
    lo = (DATA_WIDTH+1)'(SMin);
    if (v > hi) return SMax;
    if (v < lo) return SMin;
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] round_sat(
    input logic signed [SW-1:0] p0, input logic signed [SW-1:0] p1,
    input logic signed [SW-1:0] p2, input logic signed [SW-1:0] p3
  );
    logic signed [SW-1:0] s;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    s  = p0 + p1 + p2 + p3 + (SW'(1) <<< (FRAC_BITS - 1));
    r  = RW'(s >>> FRAC_BITS);
    hi = RW'(SMax);
    lo = RW'(SMin);
    if (r > hi) return SMax;
    if (r < lo) return SMin;
    return r[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [SW-1:0] px(input int unsigned k);
    return SW'(prod1_r[k]);
  endfunction

  // stage 2 registers
  logic                         v2_r;
  logic [1:0]                   cmd2_r;
  logic signed [DATA_WIDTH-1:0] a2_r [4];
  logic signed [DATA_WIDTH-1:0] q2_r [4];
  logic [PW+1:0]                ss2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  // product index = 4*a_index + b_index
  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      a2_r   <= a1_r;
      ss2_r  <= (PW+2)'(sq1_r[0]) + (PW+2)'(sq1_r[1]) + (PW+2)'(sq1_r[2])
              + (PW+2)'(sq1_r[3]);
      if (cmd1_r == CMD_ADD) begin
        for (int i = 0; i < 4; i++) q2_r[i] <= sat_add(add1_r[i]);
      end else begin
        q2_r[0] <= round_sat(px(0), -px(5), -px(10), -px(15));
        q2_r[1] <= round_sat(px(1), px(4), px(11), -px(14));
        q2_r[2] <= round_sat(px(2), -px(7), px(8), px(13));
        q2_r[3] <= round_sat(px(3), px(6), -px(9), px(12));
      end
    end
  end

  assign out_valid = v2_r;
  assign out_cmd   = cmd2_r;
  assign out_a     = a2_r;
  assign out_quick = q2_r;
  assign out_sumsq = ss2_r;
endmodule

// ----- rtl/core/qau_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating.
// q = +-min(floor(|num| * 2^(2F) / den), cap), truncating toward zero; cap = SMAX, or SMAX+1 when negative.
module qau_div
  import qau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned DEN_W      = 2 * DATA_WIDTH + 2,
  parameter int unsigned STEPS      = DATA_WIDTH + 2 * FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] num,
  input  logic                         flip,
  input  logic [DEN_W-1:0]             den,
  output logic signed [DATA_WIDTH-1:0] quo
);
  localparam int unsigned NW = DATA_WIDTH + 1;
  localparam int unsigned QW = DATA_WIDTH + 1;
  localparam int unsigned RMW = DEN_W + 1;

  logic [NW-1:0]    mag_r [STEPS+1];
  logic             neg_r [STEPS+1];
  logic [DEN_W-1:0] den_r [STEPS+1];
  logic [RMW-1:0]   rem_r [STEPS+1];
  logic [QW-1:0]    q_r   [STEPS+1];
  logic             ovf_r [STEPS+1];

  logic signed [NW-1:0] sv;
  always_comb begin
    sv = flip ? -NW'(num) : NW'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= sv[NW-1];
      mag_r[0] <= sv[NW-1] ? NW'(-sv) : NW'(sv);
      den_r[0] <= den;
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      ovf_r[0] <= 1'b0;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int I = STEPS - 1 - s;
    logic           bit_in;
    logic [RMW:0]   sh;
    logic           ge;
    logic [QW:0]    qn;
    // dividend bits enter first, then zeros for the 2F fraction shift
    if (I >= 2 * FRAC_BITS) begin : g_num
      assign bit_in = mag_r[s][I - 2*FRAC_BITS];
    end else begin : g_pad
      assign bit_in = 1'b0;
    end
    always_comb begin
      sh = {rem_r[s], bit_in};
      ge = sh >= (RMW+1)'(den_r[s]);
      qn = {q_r[s], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[s+1] <= mag_r[s];
        neg_r[s+1] <= neg_r[s];
        den_r[s+1] <= den_r[s];
        rem_r[s+1] <= RMW'(ge ? sh - (RMW+1)'(den_r[s]) : sh);
        q_r[s+1]   <= qn[QW-1:0];
        ovf_r[s+1] <= ovf_r[s] | (|qn[QW:DATA_WIDTH+1]) | qn[DATA_WIDTH];
      end
    end
  end

  logic [QW-1:0] qf;
  always_comb begin
    qf = q_r[STEPS];
    if (ovf_r[STEPS]) qf = {1'b1, {DATA_WIDTH{1'b0}}};
    if (neg_r[STEPS]) begin
      quo = (qf[DATA_WIDTH] | qf[DATA_WIDTH-1]) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
          : DATA_WIDTH'(-qf);
    end else begin
      quo = (qf[DATA_WIDTH] | qf[DATA_WIDTH-1]) ? {1'b0, {(DATA_WIDTH-1){1'b1}}}
          : qf[DATA_WIDTH-1:0];
    end
  end
endmodule

// ----- rtl/core/qau_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, saturating.
module qau_sqrt
  import qau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned IN_W       = 2 * DATA_WIDTH + 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [IN_W-1:0]       rad,
  output logic [DATA_WIDTH-1:0] root
);
  localparam int unsigned STEPS = (IN_W + 1) / 2;
  localparam int unsigned EW = 2 * STEPS;
  localparam int unsigned RW = STEPS + 2;

  logic [EW-1:0]    x_r   [STEPS+1];
  logic [RW-1:0]    rem_r [STEPS+1];
  logic [STEPS-1:0] res_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= EW'(rad);
      rem_r[0] <= '0;
      res_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [RW+1:0] tr;
    logic [RW+1:0] tst;
    logic          ge;
    always_comb begin
      tr  = {rem_r[s], x_r[s][EW-1 -: 2]};
      tst = (RW+2)'({res_r[s], 2'b01});
      ge  = tr >= tst;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s+1]   <= x_r[s] << 2;
        rem_r[s+1] <= RW'(ge ? tr - tst : tr);
        res_r[s+1] <= {res_r[s][STEPS-2:0], ge};
      end
    end
  end

  always_comb begin
    if (|res_r[STEPS][STEPS-1:DATA_WIDTH]) root = '1;
    else root = res_r[STEPS][DATA_WIDTH-1:0];
  end
endmodule

// ----- rtl/core/quaternion_arithmetic_unit.sv -----
// Quaternion arithmetic unit, signed fixed point (Q4.12 by default).
// Request channel (in_*): cmd plus quaternions a and b; valid/ready handshake.
//   cmd: add, Hamilton product, inverse of a, magnitude of a.
// Response channel (out_*): r_w..r_z, magnitude, div_by_zero; one per request.
// Pipeline: every request crosses the same pipeline: 2 front stages, the
//   divider input register plus DATA_WIDTH + 2*FRAC_BITS divider stages
//   (41 registers at defaults) and one output register.
// Throughput: one request per cycle unless the output stalls. The long
//   divider pipe (one quotient bit per stage) sets the latency; the square
//   root pipe runs in parallel and is delayed to match.
// Stall: the whole pipeline advances together. It moves when the output
//   register is empty or being read; with out_ready low and a result held,
//   the pipe freezes and in_ready drops, so nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits; data registers
//   are not reset, and the block has no configuration.
// Saturation: signed results clip to the DATA_WIDTH range, magnitude to the
//   unsigned range. Inverse of a zero quaternion returns zeros, div_by_zero=1.
module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  qau_req_if.sink    in_req,
  qau_rsp_if.source  out_rsp
);
  localparam int unsigned SSW   = 2 * DATA_WIDTH + 2;
  localparam int unsigned DSTEP = DATA_WIDTH + 2 * FRAC_BITS;
  localparam int unsigned LAT   = DSTEP + 1;
  localparam int unsigned SQST  = (SSW + 1) / 2 + 1;
  // root leaves the sqrt pipe SQST registers after f_ss; mg_r adds SQD + 1 more
  localparam int unsigned SQD   = LAT - SQST - 1;

  logic out_v_r;
  logic en;
  // pipe advances when the output slot is free or being taken
  assign en           = !out_v_r || out_rsp.ready;
  assign in_req.ready = en;

  logic signed [DATA_WIDTH-1:0] a_in [4];
  logic signed [DATA_WIDTH-1:0] b_in [4];
  assign a_in = '{in_req.a_w, in_req.a_x, in_req.a_y, in_req.a_z};
  assign b_in = '{in_req.b_w, in_req.b_x, in_req.b_y, in_req.b_z};

  logic                         f_v;
  logic [1:0]                   f_cmd;
  logic signed [DATA_WIDTH-1:0] f_a [4];
  logic signed [DATA_WIDTH-1:0] f_q [4];
  logic [SSW-1:0]               f_ss;

  qau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_req.valid && en), .in_cmd(in_req.cmd), .in_a(a_in), .in_b(b_in),
    .out_valid(f_v), .out_cmd(f_cmd), .out_a(f_a), .out_quick(f_q),
    .out_sumsq(f_ss)
  );

  // a zero divisor is replaced by one; the result is masked at the end
  logic [SSW-1:0] den;
  assign den = (f_ss == '0) ? SSW'(1) : f_ss;

  logic signed [DATA_WIDTH-1:0] inv_q [4];
  for (genvar k = 0; k < 4; k++) begin : g_div
    qau_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .DEN_W(SSW),
              .STEPS(DSTEP)) u_div (
      .clk(clk), .en(en), .num(f_a[k]), .flip(k != 0), .den(den), .quo(inv_q[k])
    );
  end

  logic [DATA_WIDTH-1:0] sq_root;
  qau_sqrt #(.DATA_WIDTH(DATA_WIDTH), .IN_W(SSW)) u_sqrt (
    .clk(clk), .en(en), .rad(f_ss), .root(sq_root)
  );

  // side pipe: valid, cmd, fast results, zero flag, and the delayed root (mg_r)
  logic                         dv_r  [LAT];
  logic [1:0]                   dc_r  [LAT];
  logic signed [DATA_WIDTH-1:0] dq_r  [LAT][4];
  logic                         dz_r  [LAT];
  logic [DATA_WIDTH-1:0]        mg_r  [SQD+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) dv_r[i] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= f_v;
      for (int i = 1; i < LAT; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0] <= f_cmd;
      dq_r[0] <= f_q;
      dz_r[0] <= (f_ss == '0);
      for (int i = 1; i < LAT; i++) begin
        dc_r[i] <= dc_r[i-1];
        dq_r[i] <= dq_r[i-1];
        dz_r[i] <= dz_r[i-1];
      end
      mg_r[0] <= sq_root;
      for (int i = 1; i <= SQD; i++) mg_r[i] <= mg_r[i-1];
    end
  end

  // output register
  logic signed [DATA_WIDTH-1:0] r_r [4];
  logic [DATA_WIDTH-1:0]        mag_r;
  logic                         dz_out_r;
  logic                         out_v_nxt;
  logic signed [DATA_WIDTH-1:0] r_nxt [4];
  logic [DATA_WIDTH-1:0]        mag_nxt;
  logic                         dz_nxt;

  assign out_v_nxt = en ? dv_r[LAT-1] : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  // fields unused by the command read as zero
  always_comb begin
    mag_nxt = '0;
    dz_nxt  = 1'b0;
    for (int i = 0; i < 4; i++) r_nxt[i] = '0;
    unique case (qau_cmd_t'(dc_r[LAT-1]))
      CMD_ADD, CMD_MUL: r_nxt = dq_r[LAT-1];
      CMD_INV: begin
        if (dz_r[LAT-1]) dz_nxt = 1'b1;
        else r_nxt = inv_q;
      end
      CMD_MAG: mag_nxt = mg_r[SQD];
      default: mag_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r      <= r_nxt;
      mag_r    <= mag_nxt;
      dz_out_r <= dz_nxt;
    end
  end

  assign out_rsp.valid       = out_v_r;
  assign out_rsp.r_w         = r_r[0];
  assign out_rsp.r_x         = r_r[1];
  assign out_rsp.r_y         = r_r[2];
  assign out_rsp.r_z         = r_r[3];
  assign out_rsp.magnitude   = mag_r;
  assign out_rsp.div_by_zero = dz_out_r;
endmodule

// ----- rtl/core/qau_checker.sv -----
`include "assert_macros.svh"
module qau_checker
  import qau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_dz,
  input logic [DATA_WIDTH-1:0] out_mag,
  input logic [DATA_WIDTH-1:0] out_rw
);
  `QAU_ASSERT_IMPL(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "in_ready during stall")
  `QAU_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "response dropped")
  `QAU_ASSERT_IMPL(a_dz_exclusive, out_valid && out_dz, out_mag == '0 && out_rw == '0, "dz with data")
endmodule

bind quaternion_arithmetic_unit qau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qau_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_req.ready), .out_valid(out_rsp.valid),
  .out_ready(out_rsp.ready), .out_dz(out_rsp.div_by_zero),
  .out_mag(out_rsp.magnitude), .out_rw(out_rsp.r_w)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import qau_pkg::*;

  localparam int unsigned DW = DataWidthDef;
  localparam int unsigned FB = FracBitsDef;
  localparam longint SMAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int unsigned NUM_RANDOM = 1150;
  localparam int unsigned DRAIN_CYCLES = 60;      // wait after the last response for stray ones
  localparam longint CYCLE_LIMIT = 400000;

  // One request: command plus quaternions a and b.
  typedef struct {
    qau_cmd_t              cmd;
    logic signed [DW-1:0]  a [4];
    logic signed [DW-1:0]  b [4];
  } quat_req_t;

  // One response, in the order w, x, y, z.
  typedef struct {
    logic signed [DW-1:0]  r [4];
    logic [DW-1:0]         magnitude;
    logic                  div_by_zero;
  } quat_rsp_t;

  // Directed row: request, plus an expected response where it is obvious.
  typedef struct {
    quat_req_t  rq;
    bit         typed;
    quat_rsp_t  rs;
  } directed_row_t;

  logic clk;
  logic rst_n;
  longint cycle_count;
  int unsigned fail_count;
  bit no_idle;                   // long burst stretch with no idling
  quat_rsp_t pending_rsp[$];     // responses still owed by the pipe

  qau_req_if #(.DATA_WIDTH(DW)) req_ch ();
  qau_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

  quaternion_arithmetic_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clip(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Rounded (ties toward +inf) Q(2FB) to Q(FB), then clipped.
  function automatic longint round_dot(longint p0, longint p1, longint p2, longint p3);
    longint acc;
    acc = p0 + p1 + p2 + p3 + (64'sd1 <<< (FB - 1));
    return clip(acc >>> FB);
  endfunction

  // Truncated v * 2^(2FB) / den, clipped to the signed range.
  function automatic longint inv_term(longint v, longint den);
    longint q;
    longint mag;
    mag = (v < 0) ? -v : v;
    q = (mag <<< (2 * FB)) / den;
    if (v < 0) return (q > SMAX + 1) ? SMIN : -q;
    return (q > SMAX) ? SMAX : q;
  endfunction

  function automatic longint floor_sqrt(longint s);
    longint root;
    longint t;
    root = 0;
    for (int k = 20; k >= 0; k--) begin
      t = root | (64'sd1 <<< k);
      if (t * t <= s) root = t;
    end
    return root;
  endfunction

  function automatic quat_rsp_t predict_quat(quat_req_t rq);
    quat_rsp_t rs;
    longint a [4];
    longint b [4];
    longint r [4];
    longint ssq;
    longint root;
    for (int i = 0; i < 4; i++) begin
      a[i] = rq.a[i];
      b[i] = rq.b[i];
      r[i] = 0;
    end
    rs.magnitude = '0;
    rs.div_by_zero = 1'b0;
    ssq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
    case (rq.cmd)
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) r[i] = clip(a[i] + b[i]);
      end
      CMD_MUL: begin
        // Hamilton product a*b
        r[0] = round_dot(a[0] * b[0], -(a[1] * b[1]), -(a[2] * b[2]), -(a[3] * b[3]));
        r[1] = round_dot(a[0] * b[1], a[1] * b[0], a[2] * b[3], -(a[3] * b[2]));
        r[2] = round_dot(a[0] * b[2], -(a[1] * b[3]), a[2] * b[0], a[3] * b[1]);
        r[3] = round_dot(a[0] * b[3], a[1] * b[2], -(a[2] * b[1]), a[3] * b[0]);
      end
      CMD_INV: begin
        if (ssq == 0) begin
          rs.div_by_zero = 1'b1;
        end else begin
          r[0] = inv_term(a[0], ssq);
          for (int i = 1; i < 4; i++) r[i] = inv_term(-a[i], ssq);
        end
      end
      default: begin
        root = floor_sqrt(ssq);
        rs.magnitude = (root > 65535) ? 16'hFFFF : root[DW-1:0];
      end
    endcase
    for (int i = 0; i < 4; i++) rs.r[i] = r[i][DW-1:0];
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // Holds valid until the handshake; the expected response is queued at
  // acceptance. Returns at the accepting edge with valid still high, so the
  // next request can follow back to back without a low/high glitch.
  task automatic send_request(quat_req_t rq, quat_rsp_t rs);
    if (!no_idle && $urandom_range(99) < 33) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= rq.cmd;
    req_ch.a_w   <= rq.a[0];
    req_ch.a_x   <= rq.a[1];
    req_ch.a_y   <= rq.a[2];
    req_ch.a_z   <= rq.a[3];
    req_ch.b_w   <= rq.b[0];
    req_ch.b_x   <= rq.b[1];
    req_ch.b_y   <= rq.b[2];
    req_ch.b_z   <= rq.b[3];
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(rs);
  endtask

  // Component value biased toward the edges of Q4.12.
  function automatic logic signed [DW-1:0] pick_component();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(8)) - 4);
      3: return 16'(int'($urandom_range(16384)) - 8192);   // within +-2.0
      4: return 16'sd4096;
      default: return DW'($urandom());
    endcase
  endfunction

  function automatic quat_req_t make_req(qau_cmd_t cmd, int aw, int ax, int ay, int az,
                                         int bw, int bx, int by, int bz);
    quat_req_t rq;
    rq.cmd = cmd;
    rq.a[0] = DW'(aw); rq.a[1] = DW'(ax); rq.a[2] = DW'(ay); rq.a[3] = DW'(az);
    rq.b[0] = DW'(bw); rq.b[1] = DW'(bx); rq.b[2] = DW'(by); rq.b[3] = DW'(bz);
    return rq;
  endfunction

  function automatic quat_rsp_t make_rsp(int rw, int rx, int ry, int rz, int mag, bit dz);
    quat_rsp_t rs;
    rs.r[0] = DW'(rw); rs.r[1] = DW'(rx); rs.r[2] = DW'(ry); rs.r[3] = DW'(rz);
    rs.magnitude = DW'(mag);
    rs.div_by_zero = dz;
    return rs;
  endfunction

  directed_row_t directed [$];

  initial begin
    quat_req_t rq;
    quat_rsp_t zero_rsp;
    directed_row_t row;

    rst_n = 1'b0;
    no_idle = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ADD;
    {req_ch.a_w, req_ch.a_x, req_ch.a_y, req_ch.a_z} = '0;
    {req_ch.b_w, req_ch.b_x, req_ch.b_y, req_ch.b_z} = '0;
    zero_rsp = make_rsp(0, 0, 0, 0, 0, 1'b0);

    // Directed table. Typed rows: saturated sums, zero inverse, clamped
    // magnitude, unit and tiny inverses. The rest go through the predictor.
    row.typed = 1'b1;
    row.rq = make_req(CMD_ADD, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    row.rs = make_rsp(32767, 32767, 32767, 32767, 0, 0);                    directed.push_back(row);
    row.rq = make_req(CMD_ADD, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    row.rs = make_rsp(-32768, -32768, -32768, -32768, 0, 0);                directed.push_back(row);
    row.rq = make_req(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
    row.rs = zero_rsp;                                                      directed.push_back(row);
    row.rq = make_req(CMD_INV, 0, 0, 0, 0, 1234, -1, 32767, -32768);
    row.rs = make_rsp(0, 0, 0, 0, 0, 1);                                    directed.push_back(row);
    row.rq = make_req(CMD_MAG, 0, 0, 0, 0, -1, -1, -1, -1);
    row.rs = zero_rsp;                                                      directed.push_back(row);
    // sum of squares 2^32 -> root 65536 clamps
    row.rq = make_req(CMD_MAG, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
    row.rs = make_rsp(0, 0, 0, 0, 65535, 0);                                directed.push_back(row);
    row.rq = make_req(CMD_INV, 4096, 0, 0, 0, 0, 0, 0, 0);
    row.rs = make_rsp(4096, 0, 0, 0, 0, 0);                                 directed.push_back(row);
    row.rq = make_req(CMD_INV, 1, 0, 0, 0, 0, 0, 0, 0);
    row.rs = make_rsp(32767, 0, 0, 0, 0, 0);                                directed.push_back(row);
    row.rq = make_req(CMD_INV, -1, 0, 0, 0, 0, 0, 0, 0);
    row.rs = make_rsp(-32768, 0, 0, 0, 0, 0);                               directed.push_back(row);
    row.rq = make_req(CMD_MAG, 4096, 0, 0, 0, 0, 0, 0, 0);
    row.rs = make_rsp(0, 0, 0, 0, 4096, 0);                                 directed.push_back(row);
    row.typed = 1'b0;
    row.rq = make_req(CMD_INV, 0, -32768, 0, 0, 0, 0, 0, 0);                directed.push_back(row);
    row.rq = make_req(CMD_INV, 0, 1, -1, 1, 0, 0, 0, 0);                    directed.push_back(row);
    row.rq = make_req(CMD_INV, 32767, 32767, -32768, 1, 0, 0, 0, 0);        directed.push_back(row);
    row.rq = make_req(CMD_MUL, 4096, 0, 0, 0, 1000, -2000, 3000, -4000);    directed.push_back(row);
    row.rq = make_req(CMD_MUL, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768, -32768);                      directed.push_back(row);
    row.rq = make_req(CMD_MUL, 32767, 32767, 32767, 32767,
                      -32768, 32767, -32768, 32767);                        directed.push_back(row);
    // product halfway between codes, both signs: rounding ties
    row.rq = make_req(CMD_MUL, 1, 0, 0, 0, 2048, -2048, 6144, -6144);       directed.push_back(row);
    row.rq = make_req(CMD_MUL, 0, 1, 2, 3, 4, 5, 6, 7);                     directed.push_back(row);
    row.rq = make_req(CMD_MAG, 32767, 32767, 32767, 32767, 0, 0, 0, 0);     directed.push_back(row);
    row.rq = make_req(CMD_MAG, 3, -4, 0, 0, 0, 0, 0, 0);                    directed.push_back(row);
    row.rq = make_req(CMD_ADD, 32767, -32768, 1, -1, -32768, 32767, -1, 1); directed.push_back(row);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].rq,
                   directed[i].typed ? directed[i].rs : predict_quat(directed[i].rq));
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      no_idle = (n >= 300 && n < 500);
      // let the pipe drain fully once, with the sender holding off
      if (n == 700) begin
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      rq.cmd = qau_cmd_t'($urandom_range(3));
      for (int k = 0; k < 4; k++) begin
        rq.a[k] = pick_component();
        rq.b[k] = pick_component();
      end
      // a zero a now and then, to hit divide by zero under random traffic
      if ($urandom_range(49) == 0) for (int k = 0; k < 4; k++) rq.a[k] = '0;
      send_request(rq, predict_quat(rq));
    end
    req_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------
  initial rsp_ch.ready = 1'b0;
  always @(posedge clk) begin
    rsp_ch.ready <= no_idle || ($urandom_range(99) >= 33);
  end

  initial fail_count = 0;
  always @(posedge clk) begin
    quat_rsp_t want;
    logic signed [DW-1:0] got [4];
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got[0] = rsp_ch.r_w;
      got[1] = rsp_ch.r_x;
      got[2] = rsp_ch.r_y;
      got[3] = rsp_ch.r_z;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with no request outstanding: r=%0d %0d %0d %0d mag=%0d dz=%0b",
                 $time, got[0], got[1], got[2], got[3], rsp_ch.magnitude, rsp_ch.div_by_zero);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want.r[i]) begin
            $display("%0t: r[%0d] expected %0d actual %0d", $time, i, want.r[i], got[i]);
            fail_count++;
          end
        end
        if (rsp_ch.magnitude !== want.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d",
                   $time, want.magnitude, rsp_ch.magnitude);
          fail_count++;
        end
        if (rsp_ch.div_by_zero !== want.div_by_zero) begin
          $display("%0t: div_by_zero expected %0b actual %0b",
                   $time, want.div_by_zero, rsp_ch.div_by_zero);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
